// File: hw/rtl/sts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, codes and byte classifiers for the s-expression token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

    // queue between front and back, in byte results (one or two tokens each)
    localparam int QDEPTH  = 4;                 // power of two
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_IDENT   = 4'd1,
        MODE_SIGN    = 4'd2,
        MODE_INT     = 4'd3,
        MODE_DEC     = 4'd4,
        MODE_STR     = 4'd5,
        MODE_STR_ESC = 4'd6,
        MODE_COMMENT = 4'd7,
        MODE_CR_SEEN = 4'd8
    } scan_mode_t;

    localparam logic [3:0] KIND_IDENT   = 4'd0;
    localparam logic [3:0] KIND_INT     = 4'd1;
    localparam logic [3:0] KIND_DEC     = 4'd2;
    localparam logic [3:0] KIND_STR     = 4'd3;
    localparam logic [3:0] KIND_UNTERM  = 4'd4;
    localparam logic [3:0] KIND_LPAREN  = 4'd5;
    localparam logic [3:0] KIND_RPAREN  = 4'd6;
    localparam logic [3:0] KIND_LBRACK  = 4'd7;
    localparam logic [3:0] KIND_RBRACK  = 4'd8;
    localparam logic [3:0] KIND_LBRACE  = 4'd9;
    localparam logic [3:0] KIND_RBRACE  = 4'd10;
    localparam logic [3:0] KIND_UNKNOWN = 4'd11;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] line;
        logic [31:0] col;
    } token_t;

    // everything one byte produced
    typedef struct packed {
        logic   two;
        token_t t0;
        token_t t1;
    } tok_pair_t;

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_id_start(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_UNDER) || letter_char(c);
    endfunction

    function automatic logic is_id_cont(input logic [7:0] c);
        return is_id_start(c) || digit_char(c);
    endfunction

    // zero when the byte is not a bracket
    function automatic logic [3:0] bracket_kind(input logic [7:0] c);
        logic [3:0] k;
        k = 4'd0;
        case (c)
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACK: k = KIND_LBRACK;
            CH_RBRACK: k = KIND_RBRACK;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            default:   k = 4'd0;
        endcase
        return k;
    endfunction

endpackage

// File: hw/rtl/sts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_front
// Scan-mode and position tracker: classifies each byte and pushes the
// tokens it finishes into the queue.
// ----------------------------------------------------------------------------
module sts_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        next_char,
    input  logic              q_full,
    output logic              push,
    output sts_pkg::tok_pair_t push_entry
);
    import sts_pkg::*;

    scan_mode_t  mode_reg, mode_next;
    logic [31:0] off_reg,  off_next;
    logic [31:0] line_reg, line_next;
    logic [31:0] col_reg,  col_next;
    logic [31:0] tso_reg,  tso_next;
    logic [31:0] tsl_reg,  tsl_next;
    logic [31:0] tsc_reg,  tsc_next;

    logic       accept;
    logic       pend_emit, idle_emit;
    token_t     pend_tok, idle_tok;
    logic       do_adv, do_idle;
    logic [3:0] bk;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign bk       = bracket_kind(next_char);

    always_comb
    begin
        mode_next = mode_reg;
        off_next  = off_reg;
        line_next = line_reg;
        col_next  = col_reg;
        tso_next  = tso_reg;
        tsl_next  = tsl_reg;
        tsc_next  = tsc_reg;
        pend_emit = 1'b0;
        idle_emit = 1'b0;
        do_adv    = 1'b0;
        do_idle   = 1'b0;

        pend_tok.kind  = KIND_IDENT;
        pend_tok.start = tso_reg;
        pend_tok.len   = off_reg - tso_reg;
        pend_tok.line  = tsl_reg;
        pend_tok.col   = tsc_reg;

        idle_tok.kind  = KIND_UNKNOWN;
        idle_tok.start = off_reg;
        idle_tok.len   = 32'd1;
        idle_tok.line  = line_reg;
        idle_tok.col   = col_reg;

        if (mode_reg == MODE_CR_SEEN && next_char == CH_LF)
        begin
            // LF of a CRLF that closed a comment: line already counted
            off_next  = off_reg + 32'd1;
            col_next  = 32'd1;
            mode_next = MODE_IDLE;
        end
        else if (next_char == CH_NUL)
        begin
            unique case (mode_reg)
                MODE_IDENT, MODE_SIGN:
                begin
                    pend_emit     = 1'b1;
                    pend_tok.kind = KIND_IDENT;
                end
                MODE_INT:
                begin
                    pend_emit     = 1'b1;
                    pend_tok.kind = KIND_INT;
                end
                MODE_DEC:
                begin
                    pend_emit     = 1'b1;
                    pend_tok.kind = KIND_DEC;
                end
                MODE_STR, MODE_STR_ESC:
                begin
                    pend_emit     = 1'b1;
                    pend_tok.kind = KIND_UNTERM;
                end
                default:
                begin
                    pend_emit = 1'b0;
                end
            endcase
            mode_next = MODE_IDLE;
            off_next  = 32'd0;
            line_next = 32'd1;
            col_next  = 32'd1;
            tso_next  = 32'd0;
            tsl_next  = 32'd1;
            tsc_next  = 32'd1;
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_id_cont(next_char))
                        do_adv = 1'b1;
                    else
                    begin
                        pend_emit     = 1'b1;
                        pend_tok.kind = KIND_IDENT;
                        do_idle       = 1'b1;
                    end
                end
                MODE_SIGN:
                begin
                    if (digit_char(next_char))
                    begin
                        mode_next = MODE_INT;
                        do_adv    = 1'b1;
                    end
                    else if (is_id_cont(next_char))
                    begin
                        mode_next = MODE_IDENT;
                        do_adv    = 1'b1;
                    end
                    else
                    begin
                        pend_emit     = 1'b1;
                        pend_tok.kind = KIND_IDENT;
                        do_idle       = 1'b1;
                    end
                end
                MODE_INT:
                begin
                    if (digit_char(next_char))
                        do_adv = 1'b1;
                    else if (next_char == CH_DOT)
                    begin
                        mode_next = MODE_DEC;
                        do_adv    = 1'b1;
                    end
                    else
                    begin
                        pend_emit     = 1'b1;
                        pend_tok.kind = KIND_INT;
                        do_idle       = 1'b1;
                    end
                end
                MODE_DEC:
                begin
                    if (digit_char(next_char))
                        do_adv = 1'b1;
                    else
                    begin
                        pend_emit     = 1'b1;
                        pend_tok.kind = KIND_DEC;
                        do_idle       = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    if (next_char == CH_QUOTE)
                    begin
                        pend_emit     = 1'b1;
                        pend_tok.kind = KIND_STR;
                        pend_tok.len  = off_reg - tso_reg + 32'd1;
                        mode_next     = MODE_IDLE;
                    end
                    else if (next_char == CH_BSLASH)
                        mode_next = MODE_STR_ESC;
                    do_adv = 1'b1;
                end
                MODE_STR_ESC:
                begin
                    mode_next = MODE_STR;
                    do_adv    = 1'b1;
                end
                MODE_COMMENT:
                begin
                    if (next_char == CH_CR)
                    begin
                        off_next  = off_reg + 32'd1;
                        line_next = line_reg + 32'd1;
                        col_next  = 32'd1;
                        mode_next = MODE_CR_SEEN;
                    end
                    else
                    begin
                        if (next_char == CH_LF)
                            mode_next = MODE_IDLE;
                        do_adv = 1'b1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            if (do_idle)
            begin
                mode_next = MODE_IDLE;
                do_adv    = 1'b1;
                if (next_char == CH_SPACE || next_char == CH_TAB ||
                    next_char == CH_VT || next_char == CH_LF)
                begin
                    mode_next = MODE_IDLE;
                end
                else if (next_char == CH_SEMI)
                    mode_next = MODE_COMMENT;
                else if (next_char == CH_QUOTE)
                begin
                    mode_next = MODE_STR;
                    tso_next  = off_reg;
                    tsl_next  = line_reg;
                    tsc_next  = col_reg;
                end
                else if (bk != 4'd0)
                begin
                    idle_emit     = 1'b1;
                    idle_tok.kind = bk;
                end
                else if (is_id_start(next_char) || digit_char(next_char))
                begin
                    if (next_char == CH_PLUS || next_char == CH_MINUS)
                        mode_next = MODE_SIGN;
                    else if (digit_char(next_char))
                        mode_next = MODE_INT;
                    else
                        mode_next = MODE_IDENT;
                    tso_next = off_reg;
                    tsl_next = line_reg;
                    tsc_next = col_reg;
                end
                else
                begin
                    idle_emit     = 1'b1;
                    idle_tok.kind = KIND_UNKNOWN;
                end
            end

            if (do_adv)
            begin
                off_next = off_reg + 32'd1;
                if (next_char == CH_LF)
                begin
                    line_next = line_reg + 32'd1;
                    col_next  = 32'd1;
                end
                else
                    col_next = col_reg + 32'd1;
            end
        end
    end

    assign push          = accept && (pend_emit || idle_emit);
    assign push_entry.two = pend_emit && idle_emit;
    assign push_entry.t0  = pend_emit ? pend_tok : idle_tok;
    assign push_entry.t1  = idle_tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            off_reg  <= 32'd0;
            line_reg <= 32'd1;
            col_reg  <= 32'd1;
            tso_reg  <= 32'd0;
            tsl_reg  <= 32'd1;
            tsc_reg  <= 32'd1;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            off_reg  <= off_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            tso_reg  <= tso_next;
            tsl_reg  <= tsl_next;
            tsc_reg  <= tsc_next;
        end
    end

endmodule

// File: hw/rtl/sts_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_queue
// Short FIFO of per-byte token groups between the scanner and output stage.
// ----------------------------------------------------------------------------
module sts_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sts_pkg::tok_pair_t push_entry,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output sts_pkg::tok_pair_t head
);
    import sts_pkg::*;

    tok_pair_t          store [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg,  count_next;
    logic               do_push;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign head    = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg[QPTR_W-1:0] == (wr_ptr_reg - rd_ptr_reg)))
        else $error("queue pointers disagree with count");

endmodule

// File: hw/rtl/sts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_back
// Output stage: splits each token group into single words and holds the
// current word in a register while the receiver stalls.
// ----------------------------------------------------------------------------
module sts_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  sts_pkg::tok_pair_t q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output sts_pkg::token_t    out_tok,
    output logic               out_last
);
    import sts_pkg::*;

    logic   sub_reg, sub_next;
    logic   valid_reg, valid_next;
    token_t tok_reg, tok_next;
    logic   last_reg, last_next;
    logic   load;
    logic   sel_last;

    assign load     = !q_empty && (!valid_reg || !out_stall);
    assign sel_last = !q_head.two || sub_reg;
    assign q_pop    = load && sel_last;

    always_comb
    begin
        sub_next   = sub_reg;
        valid_next = valid_reg && out_stall;
        tok_next   = tok_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            tok_next   = sub_reg ? q_head.t1 : q_head.t0;
            last_next  = sel_last;
            sub_next   = !sel_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg  <= tok_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;
    assign out_last  = last_reg;

    a_sub_two: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (!q_empty && q_head.two))
        else $error("second word pending without a two-token group");

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !sub_reg && q_head.two) |=> (out_valid && !out_last))
        else $error("first word of a pair marked last");

    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_last)
        else $error("group popped without its last word shown");

endmodule

// File: hw/rtl/sexpr_token_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_token_scanner_top
// Streaming s-expression lexer: one source byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with next_char. Byte 0 ends the source,
// flushes a pending token and returns the counters to offset 0, line 1,
// column 1.
// Output channel: out_valid / out_stall with one token word per transfer;
// last_of_run marks the final token caused by a byte.
// Throughput: one byte per cycle while in_stall is low. A byte that closes a token
// and also forms one (e.g. "abc)") yields two words; the output side moves one
// word per cycle while out_stall is low.
// A token caused by an accepted byte is written into the queue and from there
// into the output register.
// Between scanner and output register sits a 4-deep queue of per-byte token
// groups; when the receiver stalls the output word holds, the queue fills,
// and in_stall rises once four groups are waiting.
// Reset: scan mode idle, counters at offset 0 / line 1 / column 1, queue
// empty, out_valid low.
// ----------------------------------------------------------------------------
module sexpr_token_scanner_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  next_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  token_kind,
    output logic [31:0] start_offset,
    output logic [31:0] token_length,
    output logic [31:0] start_line,
    output logic [31:0] start_column,
    output logic        last_of_run
);
    import sts_pkg::*;

    logic      q_full, q_empty, q_push, q_pop;
    tok_pair_t push_entry, q_head;
    token_t    out_tok;

    sts_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .next_char  (next_char),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (push_entry)
    );

    sts_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    sts_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_tok    (out_tok),
        .out_last   (last_of_run)
    );

    assign token_kind   = out_tok.kind;
    assign start_offset = out_tok.start;
    assign token_length = out_tok.len;
    assign start_line   = out_tok.line;
    assign start_column = out_tok.col;

endmodule

// File: bench/sexpr_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_token_checker
// Watches both channels of the token scanner, predicts the tokens each
// accepted source byte should produce and compares them in order with the
// words leaving the block.
// ----------------------------------------------------------------------------
module sexpr_token_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  next_char,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  token_kind,
    input  logic [31:0] start_offset,
    input  logic [31:0] token_length,
    input  logic [31:0] start_line,
    input  logic [31:0] start_column,
    input  logic        last_of_run,
    output int          mismatches,
    output int          pending_tokens,
    output int          tokens_checked
);
    import sts_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        token_t tok;
        logic   last;
    } tok_word_t;

    tok_word_t   token_q[$];

    scan_mode_t  scan_state;
    logic [31:0] cur_off;
    logic [31:0] cur_line;
    logic [31:0] cur_col;
    logic [31:0] tok_off;
    logic [31:0] tok_line;
    logic [31:0] tok_col;

    function automatic logic numeral_byte(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic name_head_byte(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"], CH_UNDER, CH_PLUS, CH_MINUS};
    endfunction

    function automatic logic name_body_byte(input logic [7:0] c);
        return name_head_byte(c) || numeral_byte(c);
    endfunction

    function automatic void restart_scan();
        scan_state = MODE_IDLE;
        cur_off    = 32'd0;
        cur_line   = 32'd1;
        cur_col    = 32'd1;
        tok_off    = 32'd0;
        tok_line   = 32'd1;
        tok_col    = 32'd1;
    endfunction

    function automatic void step_pos(input logic [7:0] c);
        cur_off = cur_off + 32'd1;
        if (c == CH_LF)
        begin
            cur_line = cur_line + 32'd1;
            cur_col  = 32'd1;
        end
        else
        begin
            cur_col = cur_col + 32'd1;
        end
    endfunction

    function automatic void open_token(input scan_mode_t m);
        tok_off    = cur_off;
        tok_line   = cur_line;
        tok_col    = cur_col;
        scan_state = m;
    endfunction

    function automatic void emit_token(input logic [3:0] kind, input logic [31:0] off,
                                       input logic [31:0] len, input logic [31:0] line,
                                       input logic [31:0] col);
        tok_word_t w;
        w.tok.kind  = kind;
        w.tok.start = off;
        w.tok.len   = len;
        w.tok.line  = line;
        w.tok.col   = col;
        w.last      = 1'b0;
        token_q.push_back(w);
    endfunction

    function automatic void emit_pending(input logic [3:0] kind, input logic [31:0] len);
        emit_token(kind, tok_off, len, tok_line, tok_col);
    endfunction

    task automatic scan_byte(input logic [7:0] c);
        logic [31:0] span;
        span = cur_off - tok_off;

        // LF right after a comment-ending CR: same line break, offset only
        if (scan_state == MODE_CR_SEEN)
        begin
            scan_state = MODE_IDLE;
            if (c == CH_LF)
            begin
                cur_off = cur_off + 32'd1;
                cur_col = 32'd1;
                return;
            end
        end

        if (c == CH_NUL)
        begin
            case (scan_state)
                MODE_IDENT, MODE_SIGN:  emit_pending(KIND_IDENT, span);
                MODE_INT:               emit_pending(KIND_INT, span);
                MODE_DEC:               emit_pending(KIND_DEC, span);
                MODE_STR, MODE_STR_ESC: emit_pending(KIND_UNTERM, span);
                default: ;
            endcase
            restart_scan();
            return;
        end

        case (scan_state)
            MODE_IDENT:
            begin
                if (name_body_byte(c))
                begin
                    step_pos(c);
                    return;
                end
                emit_pending(KIND_IDENT, span);
            end
            MODE_SIGN:
            begin
                if (numeral_byte(c))
                begin
                    scan_state = MODE_INT;
                    step_pos(c);
                    return;
                end
                if (name_body_byte(c))
                begin
                    scan_state = MODE_IDENT;
                    step_pos(c);
                    return;
                end
                emit_pending(KIND_IDENT, span);   // lone sign
            end
            MODE_INT:
            begin
                if (numeral_byte(c) || c == CH_DOT)
                begin
                    if (c == CH_DOT)
                        scan_state = MODE_DEC;
                    step_pos(c);
                    return;
                end
                emit_pending(KIND_INT, span);
            end
            MODE_DEC:
            begin
                if (numeral_byte(c))
                begin
                    step_pos(c);
                    return;
                end
                emit_pending(KIND_DEC, span);
            end
            MODE_STR:
            begin
                if (c == CH_QUOTE)
                begin
                    emit_pending(KIND_STR, span + 32'd1);
                    scan_state = MODE_IDLE;
                end
                else if (c == CH_BSLASH)
                begin
                    scan_state = MODE_STR_ESC;
                end
                step_pos(c);
                return;
            end
            MODE_STR_ESC:
            begin
                scan_state = MODE_STR;
                step_pos(c);
                return;
            end
            MODE_COMMENT:
            begin
                if (c == CH_CR)
                begin
                    cur_off    = cur_off + 32'd1;
                    cur_line   = cur_line + 32'd1;
                    cur_col    = 32'd1;
                    scan_state = MODE_CR_SEEN;
                    return;
                end
                if (c == CH_LF)
                    scan_state = MODE_IDLE;
                step_pos(c);
                return;
            end
            default: ;
        endcase

        // between tokens: this byte may open one or be one
        scan_state = MODE_IDLE;
        case (c)
            CH_SPACE, CH_TAB, CH_VT, CH_LF: ;
            CH_SEMI:   scan_state = MODE_COMMENT;
            CH_QUOTE:  open_token(MODE_STR);
            CH_LPAREN: emit_token(KIND_LPAREN, cur_off, 32'd1, cur_line, cur_col);
            CH_RPAREN: emit_token(KIND_RPAREN, cur_off, 32'd1, cur_line, cur_col);
            CH_LBRACK: emit_token(KIND_LBRACK, cur_off, 32'd1, cur_line, cur_col);
            CH_RBRACK: emit_token(KIND_RBRACK, cur_off, 32'd1, cur_line, cur_col);
            CH_LBRACE: emit_token(KIND_LBRACE, cur_off, 32'd1, cur_line, cur_col);
            CH_RBRACE: emit_token(KIND_RBRACE, cur_off, 32'd1, cur_line, cur_col);
            CH_PLUS, CH_MINUS: open_token(MODE_SIGN);
            default:
            begin
                if (numeral_byte(c))
                    open_token(MODE_INT);
                else if (name_head_byte(c))
                    open_token(MODE_IDENT);
                else
                    emit_token(KIND_UNKNOWN, cur_off, 32'd1, cur_line, cur_col);
            end
        endcase
        step_pos(c);
    endtask

    task automatic take_byte(input logic [7:0] c);
        int        depth_before;
        tok_word_t w;
        depth_before = token_q.size();
        scan_byte(c);
        if (token_q.size() > depth_before)
        begin
            w = token_q.pop_back();
            w.last = 1'b1;
            token_q.push_back(w);
        end
    endtask

    task automatic check_word();
        tok_word_t want;
        if (token_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: token word with none predicted: kind %0d off %0d len %0d",
                         $time, token_kind, start_offset, token_length);
            return;
        end
        want = token_q.pop_front();
        tokens_checked++;
        if (want.tok.kind !== token_kind || want.tok.start !== start_offset ||
            want.tok.len !== token_length || want.tok.line !== start_line ||
            want.tok.col !== start_column || want.last !== last_of_run)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
            begin
                $display("%0t: token mismatch", $time);
                $display("  exp kind %0d off %0d len %0d line %0d col %0d last %0b",
                         want.tok.kind, want.tok.start, want.tok.len,
                         want.tok.line, want.tok.col, want.last);
                $display("  got kind %0d off %0d len %0d line %0d col %0d last %0b",
                         token_kind, start_offset, token_length,
                         start_line, start_column, last_of_run);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_scan();
            token_q.delete();
            mismatches     = 0;
            pending_tokens = 0;
            tokens_checked = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                take_byte(next_char);
            if (out_valid && !out_stall)
                check_word();
            pending_tokens = token_q.size();
        end
    end

endmodule

// File: bench/tb_sexpr_token_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sexpr_token_scanner_top
// Feeds the token scanner a directed source followed by random, mostly
// well-formed s-expression text under three stall mixes and one long output
// hold; the checker beside the block predicts and compares every token.
// ----------------------------------------------------------------------------
module tb_sexpr_token_scanner_top;
    import sts_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_BYTES  = 500;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  next_char;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] token_length;
    logic [31:0] start_line;
    logic [31:0] start_column;
    logic        last_of_run;

    int          mismatches;
    int          pending_tokens;
    int          tokens_checked;

    int          snd_pct;
    int          rcv_pct;
    int          hold_asks;
    int          bytes_sent;
    int          quiet_cycles;
    logic [7:0]  src_q[$];

    sexpr_token_scanner_top DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .next_char    (next_char),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .start_line   (start_line),
        .start_column (start_column),
        .last_of_run  (last_of_run)
    );

    sexpr_token_checker scan_chk
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .next_char      (next_char),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .token_kind     (token_kind),
        .start_offset   (start_offset),
        .token_length   (token_length),
        .start_line     (start_line),
        .start_column   (start_column),
        .last_of_run    (last_of_run),
        .mismatches     (mismatches),
        .pending_tokens (pending_tokens),
        .tokens_checked (tokens_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold on request
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rcv_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no transfer for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [7:0] rand_letter();
        logic [7:0] b;
        b = 8'h61 + 8'($urandom_range(25));
        if ($urandom_range(1) == 1)
            b = b - 8'h20;
        return b;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_name_byte();
        case ($urandom_range(5))
            0:       return rand_digit();
            1:       return CH_UNDER;
            2:       return $urandom_range(1) ? CH_PLUS : CH_MINUS;
            default: return rand_letter();
        endcase
    endfunction

    function automatic logic [7:0] rand_unknown();
        case ($urandom_range(5))
            0:       return CH_CR;
            1:       return CH_DOT;
            2:       return "!";
            3:       return "#";
            4:       return "@";
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    // one lexical piece of source text, mostly well formed
    task automatic add_fragment();
        int         pick;
        int         n;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 18)
        begin
            case ($urandom_range(3))
                0:       src_q.push_back(CH_UNDER);
                1:       src_q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
                default: src_q.push_back(rand_letter());
            endcase
            n = $urandom_range(6);
            repeat (n) src_q.push_back(rand_name_byte());
        end
        else if (pick < 34)
        begin
            if ($urandom_range(2) == 0)
                src_q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
            n = $urandom_range(1, 5);
            repeat (n) src_q.push_back(rand_digit());
            if ($urandom_range(1) == 1)
            begin
                src_q.push_back(CH_DOT);
                n = $urandom_range(3);
                repeat (n) src_q.push_back(rand_digit());
            end
        end
        else if (pick < 44)
        begin
            src_q.push_back(CH_QUOTE);
            n = $urandom_range(8);
            repeat (n)
            begin
                if ($urandom_range(4) == 0)
                begin
                    src_q.push_back(CH_BSLASH);
                    src_q.push_back(8'($urandom_range(1, 255)));
                end
                else
                begin
                    b = 8'($urandom_range(1, 255));
                    if (b == CH_QUOTE || b == CH_BSLASH)
                        b = rand_letter();
                    src_q.push_back(b);
                end
            end
            if ($urandom_range(9) != 0)
                src_q.push_back(CH_QUOTE);
        end
        else if (pick < 58)
        begin
            case ($urandom_range(5))
                0:       src_q.push_back(CH_LPAREN);
                1:       src_q.push_back(CH_RPAREN);
                2:       src_q.push_back(CH_LBRACK);
                3:       src_q.push_back(CH_RBRACK);
                4:       src_q.push_back(CH_LBRACE);
                default: src_q.push_back(CH_RBRACE);
            endcase
        end
        else if (pick < 70)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                case ($urandom_range(3))
                    0:       src_q.push_back(CH_TAB);
                    1:       src_q.push_back(CH_VT);
                    2:       src_q.push_back(CH_LF);
                    default: src_q.push_back(CH_SPACE);
                endcase
            end
        end
        else if (pick < 78)
        begin
            src_q.push_back(CH_SEMI);
            n = $urandom_range(6);
            repeat (n) src_q.push_back(8'($urandom_range(1, 255)));
            case ($urandom_range(2))
                0:       src_q.push_back(CH_LF);
                1:       src_q.push_back(CH_CR);
                default:
                begin
                    src_q.push_back(CH_CR);
                    src_q.push_back(CH_LF);
                end
            endcase
        end
        else if (pick < 84)
        begin
            src_q.push_back(CH_NUL);
        end
        else if (pick < 90)
        begin
            src_q.push_back(rand_unknown());
        end
        else
        begin
            src_q.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(1) == 1)
            src_q.push_back(CH_SPACE);
    endtask

    task automatic send_byte(input logic [7:0] c);
        @(negedge clk);
        while ($urandom_range(99) < snd_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        next_char <= c;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    task automatic send_source();
        while (src_q.size() > 0)
            send_byte(src_q.pop_front());
    endtask

    task automatic random_phase(input int s_pct, input int r_pct);
        snd_pct = s_pct;
        rcv_pct = r_pct;
        while (src_q.size() < PHASE_BYTES)
            add_fragment();
        send_source();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        next_char  = 8'h00;
        snd_pct    = 29;
        rcv_pct    = 72;
        hold_asks  = 0;
        bytes_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ident closed by a bracket, signed decimal closed by a bracket,
        // escaped quote, lone sign, CRLF comment end, whitespace,
        // high bytes, bare CR, flush of an open string, empty end of source
        src_q = '{CH_LPAREN, "a", "1", CH_RPAREN, CH_MINUS, "7", CH_DOT, CH_LBRACK,
                  CH_QUOTE, CH_BSLASH, CH_QUOTE, CH_QUOTE, CH_PLUS, CH_SPACE,
                  CH_SEMI, CH_CR, CH_LF, CH_TAB, CH_VT, CH_LF, 8'hFF, 8'h80, CH_CR,
                  CH_LBRACE, CH_RBRACE, CH_RBRACK, CH_QUOTE, "z", CH_NUL, CH_NUL};
        send_source();

        random_phase(29, 72);
        random_phase(72, 29);
        hold_asks++;
        random_phase(0, 0);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_tokens != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Scanned %0d source bytes; %0d tokens compared under three stall mixes",
                 bytes_sent, tokens_checked);
        $display("and one long output hold with the input backed up.");
        if (mismatches == 0 && pending_tokens == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
